@@ rtl/core/ddf_pkg.sv @@
package ddf_pkg;

  localparam int HeaderHalvesDefault = 24;

  localparam int IndexWidth = 31;
  localparam int HalfWidth  = 16;
  localparam int CfgWidth   = 32;

  // Configuration register indexes.
  localparam logic CFG_FILTER_MODE  = 1'b0;
  localparam logic CFG_STREAM_BYTES = 1'b1;

  typedef enum logic [1:0] {
    MODE_NONE    = 2'd0,
    MODE_DELTA16 = 2'd1,
    MODE_DELTA32 = 2'd2,
    MODE_PLANAR  = 2'd3
  } filter_mode_t;

  typedef enum logic {
    STATUS_OK          = 1'b0,
    STATUS_BAD_LENGTH  = 1'b1
  } status_t;

  typedef struct packed {
    logic [IndexWidth-1:0] dest_index;
    logic [HalfWidth-1:0]  half_out;
    status_t               status;
    logic                  out_last;
  } result_t;

  // Results produced by one input transaction.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

endpackage

@@ rtl/core/ddf_in_if.sv @@
interface ddf_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] half_in;
  logic        in_last;

  modport source (output valid, output half_in, output in_last, input ready);
  modport sink (input valid, input half_in, input in_last, output ready);
endinterface

@@ rtl/core/ddf_out_if.sv @@
interface ddf_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] dest_index;
  logic [15:0] half_out;
  logic        status;
  logic        out_last;

  modport source (output valid, output dest_index, output half_out, output status,
                  output out_last, input ready);
  modport sink (input valid, input dest_index, input half_out, input status,
                input out_last, output ready);
endinterface

@@ rtl/core/delta_defilter_engine.sv @@
// Channel   Role    Payload                                   Transaction
// items     sink    half_in, in_last                          valid && ready
// results   source  dest_index, half_out, status, out_last    valid && ready
// cfg       write   cfg_index (0 filter_mode, 1 stream_bytes) cfg_we
//
// One halfword is accepted per cycle while items.ready is high; its results
// (zero, one or two) enter a four-entry result queue in the same edge and
// leave it one per cycle while results.ready is high; into an empty queue,
// the first result is visible the cycle after acceptance. Items are ready while
// two slots are free, so a stalled results channel holds items before it fills.
// rst is synchronous and clears the stream state, the queue and the registers.
module delta_defilter_engine #(
  parameter int HEADER_HALVES = ddf_pkg::HeaderHalvesDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [ddf_pkg::CfgWidth-1:0]  cfg_data,
  ddf_in_if.sink                        items,
  ddf_out_if.source                     results
);

  localparam int IW = ddf_pkg::IndexWidth;
  localparam logic [IW-1:0] HdrIdx   = IW'(HEADER_HALVES);
  localparam logic [32:0]   MinBytes = 33'(2 * HEADER_HALVES);

  ddf_pkg::filter_mode_t filter_mode;
  logic [31:0]           stream_bytes;

  logic [IW-1:0] position;
  logic [31:0]   running_value;
  logic [15:0]   held_low_half;
  logic [IW-1:0] position_next;
  logic [31:0]   running_value_next;
  logic [15:0]   held_low_half_next;

  logic          accept;
  logic          room;
  logic          length_invalid;
  logic          in_header;
  logic          high_phase;
  logic [31:0]   payload;
  logic [31:0]   first_count;
  logic [31:0]   odd_bound;
  logic          even_run;
  logic [31:0]   planar_base;
  logic [15:0]   diff16;
  logic [31:0]   diff32;
  logic [31:0]   sum32;
  logic [IW-1:0] dest_even;
  logic [IW-1:0] dest_odd;

  ddf_pkg::result_pair_t push;
  ddf_pkg::result_t      head;

  assign accept = items.valid && items.ready;
  assign items.ready = room;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= ddf_pkg::MODE_NONE;
      stream_bytes <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ddf_pkg::CFG_FILTER_MODE:  filter_mode  <= ddf_pkg::filter_mode_t'(cfg_data[1:0]);
        ddf_pkg::CFG_STREAM_BYTES: stream_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // Planar split point, from configuration only.
  assign payload     = {1'b0, stream_bytes[31:1]} - 32'(HEADER_HALVES);
  assign first_count = (payload + 32'd1) >> 1;
  assign odd_bound   = 32'(HEADER_HALVES) + first_count;

  always_comb begin
    unique case (filter_mode)
      ddf_pkg::MODE_DELTA16: length_invalid = stream_bytes[0];
      ddf_pkg::MODE_DELTA32: length_invalid = (stream_bytes[1:0] != 2'd0);
      ddf_pkg::MODE_PLANAR:  length_invalid = (stream_bytes[1:0] != 2'd0) ||
                                              ({1'b0, stream_bytes} < MinBytes);
      default:               length_invalid = 1'b0;
    endcase
  end

  assign in_header  = (position < HdrIdx);
  // Parity of the payload position selects the high half of a 32-bit delta.
  assign high_phase = position[0] ^ HdrIdx[0];
  assign even_run   = ({1'b0, position} < odd_bound);
  assign dest_even  = {position[IW-2:0], 1'b0} - HdrIdx;
  assign dest_odd   = dest_even - {first_count[IW-2:0], 1'b0} + IW'(1);

  // The second planar run restarts from zero on its first halfword.
  assign planar_base = (filter_mode == ddf_pkg::MODE_PLANAR && {1'b0, position} == odd_bound)
                       ? 32'd0 : running_value;
  assign diff16      = planar_base[15:0] - items.half_in;
  assign diff32      = {items.half_in, held_low_half};
  assign sum32       = running_value - (high_phase ? diff32 : {16'd0, items.half_in});

  always_comb begin
    push               = '0;
    running_value_next = running_value;
    held_low_half_next = held_low_half;
    position_next      = position + IW'(1);

    push.first.dest_index = position;
    push.first.half_out   = items.half_in;
    push.first.status     = ddf_pkg::STATUS_OK;
    push.first.out_last   = items.in_last;
    push.second           = push.first;

    if (accept) begin
      push.count = 2'd1;
      priority if (length_invalid) begin
        push.first.half_out = '0;
        push.first.status   = ddf_pkg::STATUS_BAD_LENGTH;
      end else if (filter_mode == ddf_pkg::MODE_NONE || in_header) begin
        push.first.half_out = items.half_in;
      end else begin
        unique case (filter_mode)
          ddf_pkg::MODE_DELTA32: begin
            if (high_phase) begin
              running_value_next     = sum32;
              push.count             = 2'd2;
              push.first.dest_index  = position - IW'(1);
              push.first.half_out    = sum32[15:0];
              push.first.out_last    = 1'b0;
              push.second.half_out   = sum32[31:16];
            end else begin
              held_low_half_next = items.half_in;
              if (items.in_last) begin
                running_value_next  = sum32;
                push.first.half_out = sum32[15:0];
              end else begin
                push.count = 2'd0;
              end
            end
          end
          ddf_pkg::MODE_PLANAR: begin
            running_value_next    = {16'd0, diff16};
            push.first.dest_index = even_run ? dest_even : dest_odd;
            push.first.half_out   = diff16;
          end
          default: begin
            running_value_next  = {16'd0, diff16};
            push.first.half_out = diff16;
          end
        endcase
      end

      if (items.in_last) begin
        position_next      = '0;
        running_value_next = '0;
        held_low_half_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      running_value <= '0;
      held_low_half <= '0;
    end else if (accept) begin
      position      <= position_next;
      running_value <= running_value_next;
      held_low_half <= held_low_half_next;
    end
  end

  ddf_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .pop_valid (results.valid),
    .pop_ready (results.ready),
    .pop_data  (head)
  );

  assign results.dest_index = head.dest_index;
  assign results.half_out   = head.half_out;
  assign results.status     = head.status;
  assign results.out_last   = head.out_last;

endmodule

@@ rtl/core/ddf_result_fifo.sv @@
module ddf_result_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  ddf_pkg::result_pair_t push,
  output logic                  room,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output ddf_pkg::result_t      pop_data
);

  localparam int Depth    = 4;
  localparam int PtrWidth = $clog2(Depth);

  ddf_pkg::result_t      entries [Depth];
  logic [PtrWidth-1:0]   wr_ptr;
  logic [PtrWidth-1:0]   rd_ptr;
  logic [PtrWidth:0]     count;
  logic [PtrWidth-1:0]   wr_ptr_plus1;
  logic                  pop;

  assign wr_ptr_plus1 = wr_ptr + PtrWidth'(1);
  assign pop          = pop_valid && pop_ready;
  assign pop_valid    = (count != '0);
  assign pop_data     = entries[rd_ptr];
  // Two free slots are needed, since one transaction may yield two results.
  assign room         = (count <= (PtrWidth+1)'(Depth - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_plus1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrWidth'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PtrWidth'(1);
      end
      count <= count + (PtrWidth+1)'(push.count) - (PtrWidth+1)'(pop);
    end
  end

endmodule
